/* rtl/core/wmm_pkg.sv */
// Shared types, constants and character helpers for the wildcard mask matcher.
// Used by the compare walker and the core top level.
`timescale 1ns / 1ps

package wmm_pkg;

   // Buffer geometry
   localparam int MAX_LEN = 64;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int CHAR_W  = 8;

   // Request codes
   localparam logic [1:0] REQ_MASK = 2'd0;
   localparam logic [1:0] REQ_TEXT = 2'd1;
   localparam logic [1:0] REQ_CMP  = 2'd2;

   // Wildcard characters
   localparam logic [CHAR_W-1:0] STAR_CH  = 8'h2A;
   localparam logic [CHAR_W-1:0] QMARK_CH = 8'h3F;

   // Compare walker states
   typedef enum logic [2:0] {
      W_IDLE,
      W_LOOP,
      W_EVAL,
      W_STAR,
      W_FIN,
      W_DONE
   } walk_state_type;

   // Compare start command from the core
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] mask_len;
      logic [CNT_W-1:0] text_len;
   } walk_cmd_type;

   // Read addresses the walker drives onto the buffer RAMs
   typedef struct packed {
      logic [ADDR_W-1:0] mask_a;
      logic [ADDR_W-1:0] mask_b;
      logic [ADDR_W-1:0] text_a;
      logic [ADDR_W-1:0] text_b;
   } walk_rd_type;

   // Walker status back to the core
   typedef struct packed {
      logic busy;
      logic done;
      logic is_match;
   } walk_res_type;

   // Fold ASCII lower case letters to upper case
   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_wild(input logic [CHAR_W-1:0] c);
      return (c == STAR_CH) || (c == QMARK_CH);
   endfunction

endpackage

/* rtl/core/wmm_ram.sv */
// Generic synchronous RAM: one write port, two registered read ports.
// Stand-alone; holds the mask and string bytes.
`timescale 1ns / 1ps

module wmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write one word, register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* rtl/core/wmm_walker.sv */
// Compare sequencer: walks mask and string from both ends with one star
// backtrack point. Depends on wmm_pkg; reads the buffers through wmm_ram ports.
`timescale 1ns / 1ps

module wmm_walker
   import wmm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  walk_cmd_type      cmd,
   input  logic              result_take,
   output walk_rd_type       rd,
   input  logic [CHAR_W-1:0] mask_a_data,
   input  logic [CHAR_W-1:0] mask_b_data,
   input  logic [CHAR_W-1:0] text_a_data,
   input  logic [CHAR_W-1:0] text_b_data,
   output walk_res_type      res
);

   walk_state_type   state_ff, state_in;
   logic [CNT_W-1:0] mi_ff, mi_in;
   logic [CNT_W-1:0] si_ff, si_in;
   logic [CNT_W-1:0] mend_ff, mend_in;
   logic [CNT_W-1:0] send_ff, send_in;
   logic [CNT_W-1:0] star_pos_ff, star_pos_in;
   logic [CNT_W-1:0] star_char_ff, star_char_in;
   logic             star_valid_ff, star_valid_in;
   logic             match_ff, match_in;

   logic [CNT_W-1:0] mi_inc;
   logic [CNT_W-1:0] si_inc;
   logic [CNT_W-1:0] mend_dec;
   logic [CNT_W-1:0] send_dec;
   logic [CNT_W-1:0] back_si;
   logic             mismatch;

   assign mi_inc   = mi_ff + CNT_W'(1);
   assign si_inc   = si_ff + CNT_W'(1);
   assign mend_dec = mend_ff - CNT_W'(1);
   assign send_dec = send_ff - CNT_W'(1);
   assign back_si  = star_char_ff + CNT_W'(1);

   // State and walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= W_IDLE;
         star_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         star_valid_ff <= star_valid_in;
      end
      mi_ff        <= mi_in;
      si_ff        <= si_in;
      mend_ff      <= mend_in;
      send_ff      <= send_in;
      star_pos_ff  <= star_pos_in;
      star_char_ff <= star_char_in;
      match_ff     <= match_in;
   end

   // Next state, read addresses and walk updates
   always_comb begin
      state_in      = state_ff;
      mi_in         = mi_ff;
      si_in         = si_ff;
      mend_in       = mend_ff;
      send_in       = send_ff;
      star_pos_in   = star_pos_ff;
      star_char_in  = star_char_ff;
      star_valid_in = star_valid_ff;
      match_in      = match_ff;
      mismatch      = 1'b0;
      rd.mask_a     = mi_ff[ADDR_W-1:0];
      rd.mask_b     = mend_dec[ADDR_W-1:0];
      rd.text_a     = si_ff[ADDR_W-1:0];
      rd.text_b     = send_dec[ADDR_W-1:0];

      case (state_ff)
         W_IDLE: begin
            if (cmd.start) begin
               mi_in         = '0;
               si_in         = '0;
               mend_in       = cmd.mask_len;
               send_in       = cmd.text_len;
               star_valid_in = 1'b0;
               star_pos_in   = '0;
               star_char_in  = '0;
               match_in      = 1'b1;
               if (cmd.mask_len == '0) begin
                  state_in = W_DONE;
               end else begin
                  state_in = W_LOOP;
               end
            end
         end

         // Issue reads for both ends, or for the final check
         W_LOOP: begin
            if (mi_ff < mend_ff && si_ff < send_ff) begin
               state_in = W_EVAL;
            end else begin
               state_in = W_FIN;
            end
         end

         W_EVAL: begin
            // Keep text head on port A, fetch the byte after a star on mask A
            rd.mask_a = mi_inc[ADDR_W-1:0];
            state_in  = W_LOOP;
            if (!is_wild(mask_a_data)) begin
               if (fold(mask_a_data) != fold(text_a_data)) begin
                  mismatch = 1'b1;
               end else begin
                  mi_in = mi_inc;
                  si_in = si_inc;
               end
            end else if (!is_wild(mask_b_data)) begin
               if (fold(mask_b_data) != fold(text_b_data)) begin
                  mismatch = 1'b1;
               end else begin
                  mend_in = mend_dec;
                  send_in = send_dec;
               end
            end else if (mask_a_data == QMARK_CH) begin
               mi_in = mi_inc;
               si_in = si_inc;
            end else if (mask_b_data == QMARK_CH) begin
               mend_in = mend_dec;
               send_in = send_dec;
            end else if (mi_inc == mend_ff) begin
               // Trailing star swallows the rest
               match_in = 1'b1;
               state_in = W_DONE;
            end else begin
               if (!star_valid_ff || star_pos_ff != mi_ff) begin
                  star_valid_in = 1'b1;
                  star_pos_in   = mi_ff;
                  star_char_in  = si_ff;
               end
               state_in = W_STAR;
            end

            // Backtrack to the star, or fail
            if (mismatch) begin
               if (star_valid_ff) begin
                  mi_in        = star_pos_ff;
                  si_in        = back_si;
                  star_char_in = back_si;
               end else begin
                  match_in = 1'b0;
                  state_in = W_DONE;
               end
            end
         end

         // Byte after the star against the current string byte
         W_STAR: begin
            si_in = si_inc;
            if (fold(mask_a_data) == fold(text_a_data)) begin
               mi_in = mi_ff + CNT_W'(2);
            end
            state_in = W_LOOP;
         end

         W_FIN: begin
            match_in = (mi_ff == mend_ff && si_ff == send_ff) ||
                       (mi_inc == mend_ff && mask_a_data == STAR_CH &&
                        si_ff == send_ff);
            state_in = W_DONE;
         end

         // Hold the answer until the core takes it
         W_DONE: begin
            if (result_take) begin
               state_in = W_IDLE;
            end
         end

         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   assign res.busy     = (state_ff != W_IDLE);
   assign res.done     = (state_ff == W_DONE);
   assign res.is_match = match_ff;

endmodule

/* rtl/core/wildcard_mask_matcher_core.sv */
// Wildcard mask matcher top level: character loading, buffer RAMs, result word.
// Depends on wmm_pkg, wmm_ram and wmm_walker.
`timescale 1ns / 1ps

// Mask and string bytes load one word per cycle (req_type 0 and 1) into two
// 64-byte RAMs; bytes past 64 are dropped and flag overflow. A compare word
// (req_type 2) starts the walker, which holds req_ready low until its answer
// moves into the output register. Each trim or match step passes W_LOOP and
// W_EVAL, a star step also W_STAR, since every step reads both buffer RAMs and
// waits for the registered read data. An empty mask goes straight to W_DONE;
// otherwise req_ready stays low for the walk steps, the last loop test, the
// final check and the hand-off, and longer while the output register is full.
// Star-heavy masks that backtrack often take longest, since each backtrack
// restarts a walk over up to 64 string bytes. Loads are taken while a finished
// result waits on rsp_ready. Both buffers empty after each compare. The answer
// is a case-insensitive '?' / '*' glob match; an empty mask always matches.

module wildcard_mask_matcher_core
   import wmm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [CHAR_W-1:0] req_char_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_is_match,
   output logic              rsp_overflowed
);

   logic [CNT_W-1:0] mask_count_ff, mask_count_in;
   logic [CNT_W-1:0] text_count_ff, text_count_in;
   logic             ovf_ff, ovf_in;
   logic             ovf_hold_ff, ovf_hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_match_ff, rsp_match_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             accept;
   logic             mask_full;
   logic             text_full;
   logic             mask_we;
   logic             text_we;
   logic             take;
   walk_cmd_type     cmd;
   walk_rd_type      rd;
   walk_res_type     res;
   logic [CHAR_W-1:0] mask_a_data, mask_b_data, text_a_data, text_b_data;

   assign req_ready = !res.busy;
   assign accept    = req_valid && req_ready;
   assign mask_full = (mask_count_ff >= CNT_W'(MAX_LEN));
   assign text_full = (text_count_ff >= CNT_W'(MAX_LEN));
   assign mask_we   = accept && req_type == REQ_MASK && !mask_full;
   assign text_we   = accept && req_type == REQ_TEXT && !text_full;
   assign take      = res.done && (!rsp_valid_ff || rsp_ready);

   assign cmd.start    = accept && req_type == REQ_CMP;
   assign cmd.mask_len = mask_count_ff;
   assign cmd.text_len = text_count_ff;

   // Counts, overflow and output word
   always_comb begin
      mask_count_in = mask_count_ff;
      text_count_in = text_count_ff;
      ovf_in        = ovf_ff;
      ovf_hold_in   = ovf_hold_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (accept) begin
         case (req_type)
            REQ_MASK: begin
               if (mask_full) begin
                  ovf_in = 1'b1;
               end else begin
                  mask_count_in = mask_count_ff + CNT_W'(1);
               end
            end
            REQ_TEXT: begin
               if (text_full) begin
                  ovf_in = 1'b1;
               end else begin
                  text_count_in = text_count_ff + CNT_W'(1);
               end
            end
            REQ_CMP: begin
               ovf_hold_in   = ovf_ff;
               ovf_in        = 1'b0;
               mask_count_in = '0;
               text_count_in = '0;
            end
            default: begin
               // unused code: drop
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = res.is_match;
         rsp_ovf_in   = ovf_hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_count_ff <= '0;
         text_count_ff <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mask_count_ff <= mask_count_in;
         text_count_ff <= text_count_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ovf_hold_ff  <= ovf_hold_in;
      rsp_match_ff <= rsp_match_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_match   = rsp_match_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // Mask buffer
   wmm_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_LEN)
   ) u_mask_ram (
      .clock     (clock),
      .wr_en     (mask_we),
      .wr_addr   (mask_count_ff[ADDR_W-1:0]),
      .wr_data   (req_char_in),
      .rd_a_addr (rd.mask_a),
      .rd_a_data (mask_a_data),
      .rd_b_addr (rd.mask_b),
      .rd_b_data (mask_b_data)
   );

   // String buffer
   wmm_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_LEN)
   ) u_text_ram (
      .clock     (clock),
      .wr_en     (text_we),
      .wr_addr   (text_count_ff[ADDR_W-1:0]),
      .wr_data   (req_char_in),
      .rd_a_addr (rd.text_a),
      .rd_a_data (text_a_data),
      .rd_b_addr (rd.text_b),
      .rd_b_data (text_b_data)
   );

   // Compare sequencer
   wmm_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .result_take (take),
      .rd          (rd),
      .mask_a_data (mask_a_data),
      .mask_b_data (mask_b_data),
      .text_a_data (text_a_data),
      .text_b_data (text_b_data),
      .res         (res)
   );

endmodule
